// File: rtl/tpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared sizes, sequencer states and control structs for the translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 128;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_BITS   = 8;

  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int TLB_W      = $clog2(TLB_ENTRIES);
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int VA_W       = PAGE_BITS + OFFSET_BITS;
  localparam int PA_W       = FRAME_W + OFFSET_BITS;
  localparam int CNT_W      = 32;
  localparam int OUT_BITS   = PA_W + FRAME_W + 2 + TLB_W + 2 * CNT_W;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EVICT_RD,
    ST_EVICT,
    ST_LOAD,
    ST_STAMP,
    ST_REFILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 inval;
    logic [PAGE_BITS-1:0] inval_page;
    logic                 fill;
    logic [PAGE_BITS-1:0] fill_page;
    logic [FRAME_W-1:0]   fill_frame;
  } tlb_ctl_t;

  typedef struct packed {
    logic               hit;
    logic [TLB_W-1:0]   hit_slot;
    logic [FRAME_W-1:0] hit_frame;
    logic [TLB_W-1:0]   fill_slot;
  } tlb_sts_t;

endpackage

// File: rtl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical translation: TLB, page table, demand paging with
// free-first then FIFO or LRU frame replacement.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer contents
//  s_axis    | in        | tdata[15:0] virtual_address
//  m_axis    | out       | one translation result per input transfer
//  cfg       | in        | cfg_wdata_i[0] replacement_mode, on cfg_we_i
//
//  A TLB hit steps through idle, lookup, stamp and done; a page-table hit
//  adds refill; a fault with a free frame runs idle, lookup, load, stamp,
//  refill and done, and a FIFO victim adds evict read and evict before load;
//  an LRU fault first runs the stamp scan, which reads the use-stamp RAM
//  one frame a cycle through the single shared compare.
//  The input stays not ready while an item is in work. The result register
//  holds a finished result while the output stalls; a second result waits in
//  the done step until it drains. No clearing pass after reset.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // virtual_address [15:0]
  input  logic [tpt_pkg::VA_W-1:0]  s_axis_tdata_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // physical_address, frame_index, tlb_hit, page_fault, tlb_slot,
  // hit_total, fault_total (lowest bit up), zero padded
  output logic [tpt_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i
);
  import tpt_pkg::*;

  localparam int FC_W = FRAME_W + 1;

  state_e state_q, state_d;

  logic                 mode_q;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic                 hit_q, hit_d, fault_q, fault_d;
  logic [TLB_W-1:0]     slot_q, slot_d;
  logic [CNT_W-1:0]     hit_cnt_q, hit_cnt_d, fault_cnt_q, fault_cnt_d;
  logic [CNT_W-1:0]     use_clk_q, use_clk_d;
  logic [FRAME_W-1:0]   fifo_ptr_q, fifo_ptr_d;
  logic [FC_W-1:0]      used_q, used_d;
  logic [PAGE_COUNT-1:0] resident_q, resident_d;
  logic [FC_W-1:0]      scan_cnt_q, scan_cnt_d;
  logic                 pend_q, pend_d;
  logic [FRAME_W-1:0]   pend_idx_q, pend_idx_d;
  logic [FRAME_W-1:0]   best_idx_q, best_idx_d;
  logic [CNT_W-1:0]     best_val_q, best_val_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  // memory ports
  logic                 pf_we, pf_re, own_we, own_re, lu_we, lu_re;
  logic [FRAME_W-1:0]   pf_rdata;
  logic [PAGE_BITS-1:0] own_rdata;
  logic [CNT_W-1:0]     lu_rdata;
  logic [FRAME_W-1:0]   lu_raddr;

  tlb_ctl_t tlb_ctl;
  tlb_sts_t tlb_sts;

  tpt_tlb u_tlb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lookup_page_i (page_q),
    .ctl_i         (tlb_ctl),
    .sts_o         (tlb_sts)
  );

  // page table: page -> frame
  tpt_ram #(.DEPTH(PAGE_COUNT), .WIDTH(FRAME_W)) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (pf_we),
    .waddr_i (page_q),
    .wdata_i (frame_q),
    .re_i    (pf_re),
    .raddr_i (s_axis_tdata_i[VA_W-1:OFFSET_BITS]),
    .rdata_o (pf_rdata)
  );

  // frame -> owning page
  tpt_ram #(.DEPTH(FRAME_COUNT), .WIDTH(PAGE_BITS)) u_owner (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (frame_q),
    .wdata_i (page_q),
    .re_i    (own_re),
    .raddr_i (frame_q),
    .rdata_o (own_rdata)
  );

  // frame -> last use stamp
  tpt_ram #(.DEPTH(FRAME_COUNT), .WIDTH(CNT_W)) u_last_use (
    .clk_i   (clk_i),
    .we_i    (lu_we),
    .waddr_i (frame_q),
    .wdata_i (use_clk_d),
    .re_i    (lu_re),
    .raddr_i (lu_raddr),
    .rdata_o (lu_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    offset_d    = offset_q;
    frame_d     = frame_q;
    hit_d       = hit_q;
    fault_d     = fault_q;
    slot_d      = slot_q;
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    use_clk_d   = use_clk_q;
    fifo_ptr_d  = fifo_ptr_q;
    used_d      = used_q;
    resident_d  = resident_q;
    scan_cnt_d  = scan_cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    pf_we       = 1'b0;
    pf_re       = 1'b0;
    own_we      = 1'b0;
    own_re      = 1'b0;
    lu_we       = 1'b0;
    lu_re       = 1'b0;
    lu_raddr    = scan_cnt_q[FRAME_W-1:0];
    tlb_ctl     = '0;
    tlb_ctl.inval_page = own_rdata;
    tlb_ctl.fill_page  = page_q;
    tlb_ctl.fill_frame = frame_q;

    // drop the result once the output transfer completes
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          page_d   = s_axis_tdata_i[VA_W-1:OFFSET_BITS];
          offset_d = s_axis_tdata_i[OFFSET_BITS-1:0];
          hit_d    = 1'b0;
          fault_d  = 1'b0;
          pf_re    = 1'b1;
          state_d  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (tlb_sts.hit) begin
          hit_d     = 1'b1;
          slot_d    = tlb_sts.hit_slot;
          frame_d   = tlb_sts.hit_frame;
          hit_cnt_d = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
          state_d   = ST_STAMP;
        end else if (resident_q[page_q]) begin
          frame_d = pf_rdata;
          state_d = ST_STAMP;
        end else begin
          fault_d     = 1'b1;
          fault_cnt_d = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + 1'b1;
          if (used_q != FC_W'(FRAME_COUNT)) begin
            // frames fill from the bottom and are never freed
            frame_d = used_q[FRAME_W-1:0];
            used_d  = used_q + 1'b1;
            state_d = ST_LOAD;
          end else if (mode_q == MODE_FIFO) begin
            frame_d    = fifo_ptr_q;
            fifo_ptr_d = (fifo_ptr_q == FRAME_W'(FRAME_COUNT - 1)) ? '0
                                                                   : fifo_ptr_q + 1'b1;
            state_d    = ST_EVICT_RD;
          end else begin
            scan_cnt_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read one stamp a cycle; compare the one read last cycle
        lu_re = (scan_cnt_q < FC_W'(FRAME_COUNT));
        if (lu_re) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_cnt_q[FRAME_W-1:0];
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (pend_q && ((pend_idx_q == '0) || (lu_rdata < best_val_q))) begin
          best_val_d = lu_rdata;
          best_idx_d = pend_idx_q;
        end
        if (!lu_re && pend_q) begin
          frame_d = best_idx_d;
          state_d = ST_EVICT_RD;
        end
      end
      ST_EVICT_RD: begin
        own_re  = 1'b1;
        state_d = ST_EVICT;
      end
      ST_EVICT: begin
        // unmap the victim's previous page everywhere
        resident_d[own_rdata] = 1'b0;
        tlb_ctl.inval         = 1'b1;
        state_d               = ST_LOAD;
      end
      ST_LOAD: begin
        own_we             = 1'b1;
        pf_we              = 1'b1;
        resident_d[page_q] = 1'b1;
        state_d            = ST_STAMP;
      end
      ST_STAMP: begin
        use_clk_d = (use_clk_q == '1) ? use_clk_q : use_clk_q + 1'b1;
        lu_we     = 1'b1;
        state_d   = hit_q ? ST_DONE : ST_REFILL;
      end
      ST_REFILL: begin
        tlb_ctl.fill = 1'b1;
        slot_d       = tlb_sts.fill_slot;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = OUT_W'({fault_cnt_q, hit_cnt_q, slot_q, fault_q, hit_q,
                                frame_q, frame_q, offset_q});
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FIFO;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      use_clk_q   <= '0;
      fifo_ptr_q  <= '0;
      used_q      <= '0;
      resident_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      use_clk_q   <= use_clk_d;
      fifo_ptr_q  <= fifo_ptr_d;
      used_q      <= used_d;
      resident_q  <= resident_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    offset_q   <= offset_d;
    frame_q    <= frame_d;
    hit_q      <= hit_d;
    fault_q    <= fault_d;
    slot_q     <= slot_d;
    scan_cnt_q <= scan_cnt_d;
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: rtl/tpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/tpt_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_tlb
// TLB entry store: parallel tag match, invalidate by page, refill slot choice.
// ----------------------------------------------------------------------------
module tpt_tlb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpt_pkg::PAGE_BITS-1:0] lookup_page_i,
  input  tpt_pkg::tlb_ctl_t             ctl_i,
  output tpt_pkg::tlb_sts_t             sts_o
);
  import tpt_pkg::*;

  logic [PAGE_BITS-1:0] tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0]   frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q, valid_d;
  logic [TLB_W-1:0]     ptr_q, ptr_d;
  logic                 any_free;
  logic [TLB_W-1:0]     free_slot;

  // lowest matching and lowest free entry win: scan from the top down
  always_comb begin
    sts_o     = '0;
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == lookup_page_i)) begin
        sts_o.hit       = 1'b1;
        sts_o.hit_slot  = TLB_W'(i);
        sts_o.hit_frame = frame_q[i];
      end
      if (!valid_q[i]) begin
        any_free  = 1'b1;
        free_slot = TLB_W'(i);
      end
    end
    sts_o.fill_slot = any_free ? free_slot : ptr_q;
  end

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (ctl_i.inval) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (tag_q[i] == ctl_i.inval_page) begin
          valid_d[i] = 1'b0;
        end
      end
    end
    if (ctl_i.fill) begin
      valid_d[sts_o.fill_slot] = 1'b1;
      if (!any_free) begin
        ptr_d = (ptr_q == TLB_W'(TLB_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) begin
      tag_q[sts_o.fill_slot]   <= ctl_i.fill_page;
      frame_q[sts_o.fill_slot] <= ctl_i.fill_frame;
    end
  end

endmodule

// File: rtl/tpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks on the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [tpt_pkg::OUT_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i
);
  import tpt_pkg::*;

  localparam int FR_LO = PA_W;
  localparam int HIT_B = PA_W + FRAME_W;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_hit_xor_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[HIT_B] && m_axis_tdata_o[HIT_B+1]))
    else $error("hit and fault both set");

  a_frame_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[PA_W-1:OFFSET_BITS] == m_axis_tdata_o[FR_LO+FRAME_W-1:FR_LO])
    else $error("physical address frame differs from frame index");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready straight after a transfer");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
